// File: hw/rtl/lqs_pkg.sv
// ----------------------------------------------------------------------------
// lqs_pkg
// Shared types and constants of the lottery quantum scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lqs_pkg;

	// Item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_SCHED = 2'd2;

	// Defaults
	localparam int          DEF_MAX_SLOTS = 16;
	localparam logic [7:0]  QUANTUM_RST   = 8'd3;

	// Field widths
	localparam int TIME_W = 24;
	localparam int RAND_W = 31;

	// One slot of the process table
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [7:0]  tickets;
	} slot_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/lqs_mod.sv
// ----------------------------------------------------------------------------
// lqs_mod
// Restoring remainder unit: one dividend bit per cycle, RAND_W bits in all.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_mod #(
	parameter int TOT_W = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [lqs_pkg::RAND_W-1:0] dividend,
	input  wire logic [TOT_W-1:0]          divisor,
	output logic                           done,
	output logic [TOT_W-1:0]               remainder
);
	import lqs_pkg::*;

	localparam int CNT_W = $clog2(RAND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAND_W-1:0] dvd_q;
	logic [TOT_W-1:0]  dvs_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W:0]    trial;
	logic [TOT_W:0]    diff;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, dvd_q[RAND_W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q})
				rem_q <= diff[TOT_W-1:0];
			else
				rem_q <= trial[TOT_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/lottery_quantum_scheduler_unit.sv
// ----------------------------------------------------------------------------
// lottery_quantum_scheduler_unit
// Lottery scheduler over a table of process slots held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. Kind clear empties
//   the table and zeroes the time; kind load writes one slot. Both finish in
//   the accepting cycle, give no result word and never raise busy.
//   Kind schedule raises busy and, when it completes, presents one result
//   word for exactly one cycle with done high; the receiver cannot stall.
// Sequence of a schedule item:
//   a ticket scan reads every slot, one read per cycle from the slot memory;
//   if nothing is eligible the result follows right after the scan.
//   Otherwise the draw is reduced by a bit-serial remainder unit, a second
//   scan picks the winner and a write-back step then updates the slot.
//   The single memory read port sets the scan length.
// Reset: slot table empty (per-slot valid bits cleared), time zero, quantum 3.
//   No clearing pass is needed. The quantum register is written by cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none

module lottery_quantum_scheduler_unit #(
	parameter int MAX_SLOTS = lqs_pkg::DEF_MAX_SLOTS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [7:0]                   cfg_data,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   kind,
	input  wire logic [3:0]                   slot,
	input  wire logic [15:0]                  arrival,
	input  wire logic [15:0]                  burst,
	input  wire logic [7:0]                   tickets,
	input  wire logic [lqs_pkg::RAND_W-1:0]   random_value,
	output logic                              done,
	output logic                              idle,
	output logic                              all_done,
	output logic [3:0]                        winner,
	output logic [lqs_pkg::TIME_W-1:0]        start_time,
	output logic [7:0]                        run_length,
	output logic                              first_run,
	output logic                              finished,
	output logic [lqs_pkg::TIME_W-1:0]        end_time
);
	import lqs_pkg::*;

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int TOT_W = 8 + IDX_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_PICK = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	// slot memory and per-slot flags
	slot_entry_t             mem [MAX_SLOTS];
	slot_entry_t             rd_data;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	slot_entry_t             wr_data;
	logic [MAX_SLOTS-1:0]    valid_q;
	logic [MAX_SLOTS-1:0]    started_q;

	logic [2:0]              state_q;
	logic [7:0]              quantum_q;
	logic [TIME_W-1:0]       time_q;
	logic [IDX_W:0]          cnt_q;
	logic                    issue;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;

	logic [TOT_W-1:0]        total_q;
	logic                    work_q;
	logic                    any_q;
	logic [TOT_W-1:0]        draw_q;
	logic [TOT_W-1:0]        sum_q;
	logic [RAND_W-1:0]       rand_q;
	logic [IDX_W-1:0]        win_q;
	slot_entry_t             win_ent_q;

	logic                    accept;
	logic                    load_ok;
	logic [IDX_W-1:0]        load_addr;
	logic                    has_work;
	logic                    elig;
	logic                    last_rd;
	logic [TOT_W-1:0]        total_n;
	logic [TOT_W-1:0]        sum_n;
	logic                    work_n;
	logic                    any_n;
	logic                    mod_go;
	logic                    mod_done;
	logic [TOT_W-1:0]        mod_rem;
	logic [7:0]              run;
	logic [15:0]             rem_left;

	// result registers
	logic                    done_q;
	logic                    idle_q;
	logic                    all_done_q;
	logic [3:0]              winner_q;
	logic [TIME_W-1:0]       start_time_q;
	logic [7:0]              run_length_q;
	logic                    first_run_q;
	logic                    finished_q;
	logic [TIME_W-1:0]       end_time_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign load_ok   = (32'(slot) < MAX_SLOTS);
	assign load_addr = IDX_W'(slot);

	// scan read issue
	assign issue   = ((state_q == ST_SUM) || (state_q == ST_PICK)) &&
	                 (cnt_q < (IDX_W+1)'(MAX_SLOTS));
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign last_rd = rd_vld_s1 && (rd_idx_s1 == IDX_W'(MAX_SLOTS - 1));

	// eligibility of the word returned by the memory
	always_comb begin
		has_work = rd_vld_s1 && valid_q[rd_idx_s1] && (rd_data.remaining != 16'd0);
		elig     = has_work && ({8'd0, rd_data.arrival} <= time_q);
		work_n   = work_q | has_work;
		any_n    = any_q | elig;
		total_n  = elig ? (total_q + TOT_W'(rd_data.tickets)) : total_q;
		sum_n    = elig ? (sum_q + TOT_W'(rd_data.tickets)) : sum_q;
	end

	// run length and leftover work of the winner
	always_comb begin
		run      = (win_ent_q.remaining > {8'd0, quantum_q}) ? quantum_q
		           : win_ent_q.remaining[7:0];
		rem_left = win_ent_q.remaining - {8'd0, run};
	end

	// memory write: loads from idle, write-back of the winner
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = load_addr;
		wr_data = win_ent_q;
		if (accept && (kind == KIND_LOAD) && load_ok) begin
			wr_en           = 1'b1;
			wr_data.arrival   = arrival;
			wr_data.remaining = burst;
			wr_data.tickets   = (tickets == 8'd0) ? 8'd1 : tickets;
		end else if (state_q == ST_RUN) begin
			wr_en             = 1'b1;
			wr_addr           = win_q;
			wr_data.remaining = rem_left;
		end
	end

	// slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	assign mod_go = (state_q == ST_SUM) && last_rd && work_n && any_n;

	lqs_mod #(
		.TOT_W (TOT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (mod_go),
		.dividend  (rand_q),
		.divisor   (total_n),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			quantum_q  <= QUANTUM_RST;
			time_q     <= '0;
			valid_q    <= '0;
			started_q  <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			if (issue)
				cnt_q <= cnt_q + (IDX_W+1)'(1);
			if (cfg_we)
				quantum_q <= cfg_data;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_CLEAR) begin
							valid_q   <= '0;
							started_q <= '0;
							time_q    <= '0;
						end else if (kind == KIND_LOAD) begin
							if (load_ok) begin
								valid_q[load_addr]   <= 1'b1;
								started_q[load_addr] <= 1'b0;
							end
						end else if (kind == KIND_SCHED) begin
							cnt_q   <= '0;
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM: begin
					if (last_rd) begin
						if (!work_n) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else if (!any_n) begin
							done_q  <= 1'b1;
							time_q  <= time_q + TIME_W'(1);
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						cnt_q   <= '0;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (elig && (draw_q < sum_n))
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					started_q[win_q] <= 1'b1;
					time_q           <= time_q + TIME_W'(run);
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan accumulators and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		unique case (state_q)
			ST_IDLE: begin
				total_q <= '0;
				sum_q   <= '0;
				work_q  <= 1'b0;
				any_q   <= 1'b0;
				rand_q  <= random_value;
			end
			ST_SUM: begin
				total_q <= total_n;
				work_q  <= work_n;
				any_q   <= any_n;
				if (last_rd) begin
					idle_q       <= work_n;
					all_done_q   <= !work_n;
					winner_q     <= '0;
					start_time_q <= time_q;
					run_length_q <= '0;
					first_run_q  <= 1'b0;
					finished_q   <= 1'b0;
					end_time_q   <= work_n ? (time_q + TIME_W'(1)) : time_q;
				end
			end
			ST_MOD: begin
				draw_q <= mod_rem;
			end
			ST_PICK: begin
				sum_q <= sum_n;
				if (elig && (draw_q < sum_n)) begin
					win_q     <= rd_idx_s1;
					win_ent_q <= rd_data;
				end
			end
			ST_RUN: begin
				idle_q       <= 1'b0;
				all_done_q   <= 1'b0;
				winner_q     <= 4'(win_q);
				start_time_q <= time_q;
				run_length_q <= run;
				first_run_q  <= !started_q[win_q];
				finished_q   <= (rem_left == 16'd0);
				end_time_q   <= time_q + TIME_W'(run);
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign idle       = idle_q;
	assign all_done   = all_done_q;
	assign winner     = winner_q;
	assign start_time = start_time_q;
	assign run_length = run_length_q;
	assign first_run  = first_run_q;
	assign finished   = finished_q;
	assign end_time   = end_time_q;

endmodule

`default_nettype wire

// File: hw/rtl/lqs_checker.sv
// ----------------------------------------------------------------------------
// lqs_checker
// Port-level checks of the lottery quantum scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lqs_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [1:0]            kind,
	input  wire logic                  done,
	input  wire logic                  idle,
	input  wire logic                  all_done,
	input  wire logic [lqs_pkg::TIME_W-1:0] start_time,
	input  wire logic [7:0]            run_length,
	input  wire logic [lqs_pkg::TIME_W-1:0] end_time
);
	import lqs_pkg::*;

	// a schedule word occupies the block
	a_sched_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_SCHED)) |=> busy)
		else $error("schedule word did not raise busy");

	// idle and all done never come together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(idle && all_done))
		else $error("idle and all_done both set");

	// all done leaves time unchanged
	a_all_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && all_done) |-> ((end_time == start_time) && (run_length == 8'd0)))
		else $error("all_done result moved time");

	// idle step advances time by one
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle) |-> (end_time == TIME_W'(start_time + TIME_W'(1))))
		else $error("idle result did not advance time by one");

	// a run advances time by its length
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !idle && !all_done) |->
		(end_time == TIME_W'(start_time + TIME_W'(run_length))))
		else $error("run result time mismatch");

endmodule

bind lottery_quantum_scheduler_unit lqs_checker u_lqs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.kind       (kind),
	.done       (done),
	.idle       (idle),
	.all_done   (all_done),
	.start_time (start_time),
	.run_length (run_length),
	.end_time   (end_time)
);

`default_nettype wire

// File: sim/lottery_quantum_scheduler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lottery_quantum_scheduler_unit_test
// Self-checking bench for the lottery quantum scheduler. A directed table
// walks the corner cases, then random clear / load / schedule sequences run
// under several quantum settings and sender idle rates. Every result word is
// checked field by field against a typed row or the bench's lottery predictor.
// ----------------------------------------------------------------------------

module lottery_quantum_scheduler_unit_test;
	import lqs_pkg::*;

	localparam int          SLOTS      = DEF_MAX_SLOTS;
	localparam logic [1:0]  KIND_NONE  = 2'd3;   // unused kind, ignored by the block
	localparam int          SETTLE     = 80;     // covers worst schedule latency
	localparam int          LIMIT      = 1000000;
	localparam int          PHASE_WORDS = 125;

	// One command word
	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        slot;
		logic [15:0]       arrival;
		logic [15:0]       burst;
		logic [7:0]        tickets;
		logic [RAND_W-1:0] rnd;
	} cmd_t;

	// One result word
	typedef struct packed {
		logic              idle;
		logic              all_done;
		logic [3:0]        winner;
		logic [TIME_W-1:0] start_time;
		logic [7:0]        run_length;
		logic              first_run;
		logic              finished;
		logic [TIME_W-1:0] end_time;
	} sched_word_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        typed;
		sched_word_t want;
	} dir_row_t;

	localparam sched_word_t NO_WORD = '0;

	// Directed table: typed results only where they are obvious by hand
	localparam dir_row_t DIRECTED [25] = '{
		// schedule right after reset: nothing loaded
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b1, 4'd0, 24'd0, 8'd0, 1'b0, 1'b0, 24'd0}},
		'{'{KIND_NONE, 4'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 31'h7FFFFFFF}, 1'b0, NO_WORD},
		// zero tickets stored as one; not arrived yet -> idle step
		'{'{KIND_LOAD, 4'd0, 16'd5, 16'd4, 8'd0, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b1, 1'b0, 4'd0, 24'd0, 8'd0, 1'b0, 1'b0, 24'd1}},
		'{'{KIND_LOAD, 4'd15, 16'd0, 16'hFFFF, 8'd255, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b0, 4'd15, 24'd1, 8'd3, 1'b1, 1'b0, 24'd4}},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'h7FFFFFFF}, 1'b1,
			'{1'b0, 1'b0, 4'd15, 24'd4, 8'd3, 1'b0, 1'b0, 24'd7}},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b0, 4'd0, 24'd7, 8'd3, 1'b1, 1'b0, 24'd10}},
		// remaining work below the quantum finishes the slot
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b0, 4'd0, 24'd10, 8'd1, 1'b0, 1'b1, 24'd11}},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd255}, 1'b1,
			'{1'b0, 1'b0, 4'd15, 24'd11, 8'd3, 1'b0, 1'b0, 24'd14}},
		'{'{KIND_LOAD, 4'd7, 16'hFFFF, 16'd1, 8'd128, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_LOAD, 4'd8, 16'd0, 16'd2, 8'd1, 31'd0}, 1'b0, NO_WORD},
		// draw on the last ticket of the top slot, then wrap to the first
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd255}, 1'b1,
			'{1'b0, 1'b0, 4'd15, 24'd14, 8'd3, 1'b0, 1'b0, 24'd17}},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd256}, 1'b1,
			'{1'b0, 1'b0, 4'd8, 24'd17, 8'd2, 1'b1, 1'b1, 24'd19}},
		'{'{KIND_SCHED, 4'd3, 16'h1234, 16'h4321, 8'h5A, 31'h2AAAAAAA}, 1'b0, NO_WORD},
		// clear, then an empty-slot load still leaves nothing to do
		'{'{KIND_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b1, 4'd0, 24'd0, 8'd0, 1'b0, 1'b0, 24'd0}},
		'{'{KIND_LOAD, 4'd3, 16'd0, 16'd0, 8'd9, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'd0}, 1'b1,
			'{1'b0, 1'b1, 4'd0, 24'd0, 8'd0, 1'b0, 1'b0, 24'd0}},
		'{'{KIND_LOAD, 4'd1, 16'd0, 16'd100, 8'd85, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_LOAD, 4'd2, 16'd0, 16'd7, 8'd170, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_LOAD, 4'd4, 16'd1, 16'd3, 8'd2, 31'd0}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'h55555555}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'h00001234}, 1'b0, NO_WORD},
		'{'{KIND_SCHED, 4'd0, 16'd0, 16'd0, 8'd0, 31'h7FFFFFFE}, 1'b0, NO_WORD}
	};

	// DUT signals
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [7:0]        cfg_data = '0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        kind = '0;
	logic [3:0]        slot = '0;
	logic [15:0]       arrival = '0;
	logic [15:0]       burst = '0;
	logic [7:0]        tickets = '0;
	logic [RAND_W-1:0] random_value = '0;
	logic              done;
	logic              idle;
	logic              all_done;
	logic [3:0]        winner;
	logic [TIME_W-1:0] start_time;
	logic [7:0]        run_length;
	logic              first_run;
	logic              finished;
	logic [TIME_W-1:0] end_time;

	// Predictor state
	logic [15:0]       proc_arrival [SLOTS] = '{default: '0};
	logic [15:0]       proc_left    [SLOTS] = '{default: '0};
	logic [7:0]        proc_tix     [SLOTS] = '{default: '0};
	logic              proc_begun   [SLOTS] = '{default: '0};
	logic [TIME_W-1:0] sys_time = '0;
	logic [7:0]        cur_quantum = QUANTUM_RST;

	sched_word_t pending_runs [$];
	int          err_count = 0;
	int          cycle_count = 0;
	int          sender_idle = 0;
	int          sent_words = 0;

	lottery_quantum_scheduler_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.arrival      (arrival),
		.burst        (burst),
		.tickets      (tickets),
		.random_value (random_value),
		.done         (done),
		.idle         (idle),
		.all_done     (all_done),
		.winner       (winner),
		.start_time   (start_time),
		.run_length   (run_length),
		.first_run    (first_run),
		.finished     (finished),
		.end_time     (end_time)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Lottery predictor: updates the table and returns 1 when a word is due
	function automatic bit lottery_step(input cmd_t c, output sched_word_t w);
		int unsigned total;
		int unsigned draw;
		int unsigned acc;
		int          sel;
		bit          work;
		bit          any;
		bit          found;
		logic [15:0] run;
		w = '0;
		case (c.kind)
			KIND_CLEAR: begin
				foreach (proc_left[s]) begin
					proc_left[s]  = '0;
					proc_begun[s] = 1'b0;
				end
				sys_time = '0;
				return 1'b0;
			end
			KIND_LOAD: begin
				proc_arrival[c.slot] = c.arrival;
				proc_left[c.slot]    = c.burst;
				proc_tix[c.slot]     = (c.tickets == 0) ? 8'd1 : c.tickets;
				proc_begun[c.slot]   = 1'b0;
				return 1'b0;
			end
			KIND_SCHED: begin
			end
			default: return 1'b0;
		endcase

		// ticket total over arrived slots with work left
		total = 0;
		work  = 1'b0;
		any   = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (proc_left[s] != 0) begin
				work = 1'b1;
				if ({8'd0, proc_arrival[s]} <= sys_time) begin
					any = 1'b1;
					total += 32'(proc_tix[s]);
				end
			end
		end
		w.start_time = sys_time;
		if (!work) begin
			w.all_done = 1'b1;
			w.end_time = sys_time;
			return 1'b1;
		end
		if (!any) begin
			sys_time   = sys_time + TIME_W'(1);
			w.idle     = 1'b1;
			w.end_time = sys_time;
			return 1'b1;
		end

		// walk the running ticket sum to find the winner
		draw  = 32'(c.rnd) % total;
		acc   = 0;
		sel   = 0;
		found = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (!found && proc_left[s] != 0 && {8'd0, proc_arrival[s]} <= sys_time) begin
				acc += 32'(proc_tix[s]);
				if (draw < acc) begin
					sel   = s;
					found = 1'b1;
				end
			end
		end

		w.winner       = sel[3:0];
		w.first_run    = !proc_begun[sel];
		proc_begun[sel] = 1'b1;
		run = (proc_left[sel] > {8'd0, cur_quantum}) ? {8'd0, cur_quantum} : proc_left[sel];
		proc_left[sel] = proc_left[sel] - run;
		sys_time       = sys_time + TIME_W'(run);
		w.run_length   = run[7:0];
		w.finished     = (proc_left[sel] == 0);
		w.end_time     = sys_time;
		return 1'b1;
	endfunction

	function automatic cmd_t random_cmd(input logic [1:0] k);
		cmd_t c;
		int   roll;
		c.kind = k;
		c.slot = 4'($urandom_range(15));
		roll = $urandom_range(99);
		if (roll < 65)
			c.arrival = 16'($urandom_range(24));
		else if (roll < 88)
			c.arrival = 16'($urandom_range(400));
		else
			c.arrival = 16'($urandom_range(65535));
		roll = $urandom_range(99);
		if (roll < 70)
			c.burst = 16'($urandom_range(12, 1));
		else if (roll < 82)
			c.burst = '0;
		else if (roll < 95)
			c.burst = 16'($urandom_range(600, 13));
		else
			c.burst = 16'($urandom_range(65535));
		roll = $urandom_range(99);
		if (roll < 8)
			c.tickets = '0;
		else if (roll < 16)
			c.tickets = 8'd255;
		else
			c.tickets = 8'($urandom_range(255));
		if ($urandom_range(99) < 15)
			c.rnd = RAND_W'($urandom_range(511));
		else
			c.rnd = RAND_W'($urandom);
		return c;
	endfunction

	// Drive one command word, wait for it to be taken, record what it should give
	task automatic send_word(input cmd_t c, input bit typed = 1'b0,
			input sched_word_t want = '0);
		sched_word_t w;
		int          gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			@(posedge clk);
			gap++;
		end
		start        <= 1'b1;
		kind         <= c.kind;
		slot         <= c.slot;
		arrival      <= c.arrival;
		burst        <= c.burst;
		tickets      <= c.tickets;
		random_value <= c.rnd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (lottery_step(c, w))
			pending_runs.insert(pending_runs.size(), typed ? want : w);
	endtask

	// Quantum write, only once the block has drained
	task automatic set_quantum(input logic [7:0] q);
		start <= 1'b0;
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= q;
		@(posedge clk);
		cfg_we      <= 1'b0;
		cur_quantum  = q;
	endtask

	// Mostly clear, fill some slots, run the lottery with occasional reloads and noise
	task automatic run_episode();
		int n_loads;
		int n_steps;
		int roll;
		if ($urandom_range(99) < 85) begin
			send_word(random_cmd(KIND_CLEAR));
			sent_words++;
		end
		n_loads = $urandom_range(16, 1);
		repeat (n_loads) begin
			send_word(random_cmd(KIND_LOAD));
			sent_words++;
		end
		n_steps = $urandom_range(40, 3);
		repeat (n_steps) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				send_word(random_cmd(KIND_LOAD));
				sent_words++;
			end else if (roll < 9) begin
				send_word(random_cmd(KIND_NONE));
			end else if (roll < 10) begin
				send_word(random_cmd(KIND_CLEAR));
				sent_words++;
			end else begin
				send_word(random_cmd(KIND_SCHED));
				sent_words++;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		sched_word_t want;
		if (arst_n && done) begin
			if (pending_runs.size() == 0) begin
				$error("result word with nothing expected");
				err_count++;
			end else begin
				want = pending_runs.pop_front();
				check_field("idle", 32'(want.idle), 32'(idle));
				check_field("all_done", 32'(want.all_done), 32'(all_done));
				check_field("winner", 32'(want.winner), 32'(winner));
				check_field("start_time", 32'(want.start_time), 32'(start_time));
				check_field("run_length", 32'(want.run_length), 32'(run_length));
				check_field("first_run", 32'(want.first_run), 32'(first_run));
				check_field("finished", 32'(want.finished), 32'(finished));
				check_field("end_time", 32'(want.end_time), 32'(end_time));
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus
	initial begin : stimulus
		logic [7:0] q_fixed [4];
		int         idle_mode [4];
		q_fixed   = '{8'd1, 8'd255, 8'd0, 8'd3};
		idle_mode = '{0, 86, 0, 21};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset quantum
		foreach (DIRECTED[i])
			send_word(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);

		// random phases: quantum extremes and random values, rotating idle rates
		for (int ph = 0; ph < 8; ph++) begin
			set_quantum((ph % 2) ? 8'($urandom_range(255)) : q_fixed[ph / 2]);
			sender_idle = idle_mode[(ph + ph / 4) % 4];
			sent_words  = 0;
			while (sent_words < PHASE_WORDS)
				run_episode();
		end

		start <= 1'b0;
		while (pending_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lqs_pkg.sv
hw/rtl/lqs_mod.sv
hw/rtl/lottery_quantum_scheduler_unit.sv
hw/rtl/lqs_checker.sv
sim/lottery_quantum_scheduler_unit_test.sv
